/* hdl/lbc_pkg.sv */
// shared constants, codes and the entry record of the block buffer cache
package lbc_pkg;

   localparam int ENTRIES     = 16;
   localparam int DEVICE_BITS = 8;
   localparam int BLOCK_BITS  = 24;
   localparam int COUNT_BITS  = 8;

   // fixed widths of the request and response fields
   localparam int DEVICE_FIELD_BITS = 8;
   localparam int BLOCK_FIELD_BITS  = 24;
   localparam int SLOT_BITS         = 4;
   localparam int STATUS_BITS       = 2;

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = IDX_BITS + 1;

   localparam logic MODE_ACQUIRE = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_HELD  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_SATURATED = 2'd3;

   typedef struct packed {
      logic                   assigned;
      logic [DEVICE_BITS-1:0] device;
      logic [BLOCK_BITS-1:0]  block;
      logic                   data_valid;
      logic [COUNT_BITS-1:0]  refs;
      logic [IDX_BITS-1:0]    rank;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

/* hdl/lru_block_buffer_cache.sv */
// top level of the block buffer cache tag and recency manager
//
// Request channel: a beat is taken at a rising edge where start is high and
// busy is low. req_mode selects acquire (device, block number) or release
// (slot). Busy stays high until the beat's response has been produced.
// Response channel: rsp_strobe is high for exactly one cycle with the
// result slot, hit, needs_fill and status; the receiver cannot hold it off.
// Every entry record (tag, count, recency rank) sits in one ram with a
// registered read; a flip-flop per entry marks it written, and an
// unwritten entry reads as its reset value, so no clearing pass is run.
// Acquire: a scan reads all ENTRIES records one a cycle, then the grant
// state writes the found or chosen entry back, if there is one.
// Release: one read of the slot, then no write if the slot is not held,
// one write, or, when the count drops to zero, a read-modify-write sweep
// of all entries to age the ranks; a slot out of range is answered unread.
// A new request can be taken in the cycle the strobe is shown.
// Reset (synchronous, active high) empties the cache: no entry assigned,
// all counts zero, entry i at recency rank i.
module lru_block_buffer_cache (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_mode,
   input  logic [lbc_pkg::DEVICE_FIELD_BITS-1:0] req_device,
   input  logic [lbc_pkg::BLOCK_FIELD_BITS-1:0]  req_block_number,
   input  logic [lbc_pkg::SLOT_BITS-1:0]         req_slot,
   output logic                                  rsp_strobe,
   output logic [lbc_pkg::SLOT_BITS-1:0]         rsp_result_slot,
   output logic                                  rsp_hit,
   output logic                                  rsp_needs_fill,
   output logic [lbc_pkg::STATUS_BITS-1:0]       rsp_status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_GRANT = 3'd2;
   localparam logic [2:0] ST_RCHK  = 3'd3;
   localparam logic [2:0] ST_SWEEP = 3'd4;

   localparam int IB = lbc_pkg::IDX_BITS;
   localparam int CB = lbc_pkg::CNT_BITS;

   logic [2:0]                          state_ff, state_in;
   logic [CB-1:0]                       idx_ff, idx_in;
   logic [IB-1:0]                       dat_idx_ff, dat_idx_in;
   logic                                dat_live_ff, dat_live_in;
   logic [lbc_pkg::DEVICE_BITS-1:0]     dev_ff, dev_in;
   logic [lbc_pkg::BLOCK_BITS-1:0]      blk_ff, blk_in;
   logic [lbc_pkg::SLOT_BITS-1:0]       slot_ff, slot_in;
   logic                                hit_ff, hit_in;
   logic [IB-1:0]                       hit_idx_ff, hit_idx_in;
   lbc_pkg::entry_type                  hit_rec_ff, hit_rec_in;
   logic                                vic_ff, vic_in;
   logic [IB-1:0]                       vic_idx_ff, vic_idx_in;
   logic [IB-1:0]                       vic_rank_ff, vic_rank_in;
   logic [IB-1:0]                       rank_ff, rank_in;
   logic [lbc_pkg::ENTRIES-1:0]         written_ff, written_in;
   logic                                rsp_strobe_ff, rsp_strobe_in;
   logic [lbc_pkg::SLOT_BITS-1:0]       rsp_slot_ff, rsp_slot_in;
   logic                                rsp_hit_ff, rsp_hit_in;
   logic                                rsp_fill_ff, rsp_fill_in;
   logic [lbc_pkg::STATUS_BITS-1:0]     rsp_status_ff, rsp_status_in;

   logic                                ram_wr_en;
   logic [IB-1:0]                       ram_wr_addr;
   lbc_pkg::entry_type                  ram_wr_data;
   logic                                ram_rd_en;
   logic [IB-1:0]                       ram_rd_addr;
   lbc_pkg::entry_type                  ram_rd_data;

   lbc_pkg::entry_type                  cur_rec;
   lbc_pkg::entry_type                  new_rec;
   logic                                cur_match;
   logic                                last_dat;
   logic                                issue_ok;

   lbc_ram #(
      .WIDTH (lbc_pkg::ENTRY_BITS),
      .DEPTH (lbc_pkg::ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // an entry never written reads as its reset value
   always_comb begin
      if (written_ff[dat_idx_ff]) begin
         cur_rec = ram_rd_data;
      end else begin
         cur_rec          = '0;
         cur_rec.rank     = dat_idx_ff;
      end
   end

   assign cur_match = cur_rec.assigned && (cur_rec.device == dev_ff) && (cur_rec.block == blk_ff);
   assign last_dat  = dat_live_ff && (dat_idx_ff == IB'(lbc_pkg::ENTRIES - 1));
   assign issue_ok  = idx_ff < CB'(lbc_pkg::ENTRIES);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      dat_idx_in    = dat_idx_ff;
      dat_live_in   = 1'b0;
      dev_in        = dev_ff;
      blk_in        = blk_ff;
      slot_in       = slot_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_rec_in    = hit_rec_ff;
      vic_in        = vic_ff;
      vic_idx_in    = vic_idx_ff;
      vic_rank_in   = vic_rank_ff;
      rank_in       = rank_ff;
      written_in    = written_ff;
      rsp_strobe_in = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = dat_idx_ff;
      ram_wr_data   = cur_rec;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff[IB-1:0];
      new_rec       = cur_rec;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dev_in  = lbc_pkg::DEVICE_BITS'(req_device);
               blk_in  = lbc_pkg::BLOCK_BITS'(req_block_number);
               slot_in = req_slot;
               if (req_mode == lbc_pkg::MODE_ACQUIRE) begin
                  idx_in   = '0;
                  hit_in   = 1'b0;
                  vic_in   = 1'b0;
                  state_in = ST_SCAN;
               end else if (32'(req_slot) >= lbc_pkg::ENTRIES) begin
                  rsp_strobe_in = 1'b1;
                  rsp_slot_in   = req_slot;
                  rsp_hit_in    = 1'b0;
                  rsp_fill_in   = 1'b0;
                  rsp_status_in = lbc_pkg::STATUS_NOT_HELD;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IB'(req_slot);
                  dat_idx_in  = IB'(req_slot);
                  dat_live_in = 1'b1;
                  state_in    = ST_RCHK;
               end
            end
         end

         ST_SCAN: begin
            if (issue_ok) begin
               ram_rd_en   = 1'b1;
               dat_idx_in  = idx_ff[IB-1:0];
               dat_live_in = 1'b1;
               idx_in      = idx_ff + CB'(1);
            end
            if (dat_live_ff) begin
               if (cur_match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = dat_idx_ff;
                  hit_rec_in = cur_rec;
               end
               // oldest unreferenced entry wins, first one on a tie
               if ((cur_rec.refs == '0) && (!vic_ff || (cur_rec.rank > vic_rank_ff))) begin
                  vic_in      = 1'b1;
                  vic_idx_in  = dat_idx_ff;
                  vic_rank_in = cur_rec.rank;
               end
            end
            if (last_dat) begin
               state_in = ST_GRANT;
            end
         end

         ST_GRANT: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (hit_ff) begin
               new_rec            = hit_rec_ff;
               new_rec.data_valid = 1'b1;
               if (hit_rec_ff.refs != '1) begin
                  new_rec.refs = hit_rec_ff.refs + lbc_pkg::COUNT_BITS'(1);
               end
               ram_wr_en   = 1'b1;
               ram_wr_addr = hit_idx_ff;
               ram_wr_data = new_rec;
               written_in[hit_idx_ff] = 1'b1;
               rsp_slot_in   = lbc_pkg::SLOT_BITS'(hit_idx_ff);
               rsp_hit_in    = 1'b1;
               rsp_fill_in   = !hit_rec_ff.data_valid;
               rsp_status_in = (hit_rec_ff.refs == '1) ? lbc_pkg::STATUS_SATURATED
                                                       : lbc_pkg::STATUS_OK;
            end else if (vic_ff) begin
               new_rec.assigned   = 1'b1;
               new_rec.device     = dev_ff;
               new_rec.block      = blk_ff;
               new_rec.data_valid = 1'b1;
               new_rec.refs       = lbc_pkg::COUNT_BITS'(1);
               new_rec.rank       = vic_rank_ff;
               ram_wr_en   = 1'b1;
               ram_wr_addr = vic_idx_ff;
               ram_wr_data = new_rec;
               written_in[vic_idx_ff] = 1'b1;
               rsp_slot_in   = lbc_pkg::SLOT_BITS'(vic_idx_ff);
               rsp_hit_in    = 1'b0;
               rsp_fill_in   = 1'b1;
               rsp_status_in = lbc_pkg::STATUS_OK;
            end else begin
               rsp_slot_in   = '0;
               rsp_hit_in    = 1'b0;
               rsp_fill_in   = 1'b0;
               rsp_status_in = lbc_pkg::STATUS_NO_FREE;
            end
         end

         ST_RCHK: begin
            rsp_slot_in = slot_ff;
            rsp_hit_in  = 1'b0;
            rsp_fill_in = 1'b0;
            if (cur_rec.refs == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = lbc_pkg::STATUS_NOT_HELD;
               state_in      = ST_IDLE;
            end else if (cur_rec.refs == lbc_pkg::COUNT_BITS'(1)) begin
               // last reference gone: age the younger entries in a sweep
               rank_in  = cur_rec.rank;
               idx_in   = '0;
               state_in = ST_SWEEP;
            end else begin
               new_rec.refs  = cur_rec.refs - lbc_pkg::COUNT_BITS'(1);
               ram_wr_en     = 1'b1;
               ram_wr_data   = new_rec;
               written_in[dat_idx_ff] = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_status_in = lbc_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end
         end

         ST_SWEEP: begin
            if (issue_ok) begin
               ram_rd_en   = 1'b1;
               dat_idx_in  = idx_ff[IB-1:0];
               dat_live_in = 1'b1;
               idx_in      = idx_ff + CB'(1);
            end
            if (dat_live_ff) begin
               if (dat_idx_ff == IB'(slot_ff)) begin
                  new_rec.refs = '0;
                  new_rec.rank = '0;
               end else if (cur_rec.rank < rank_ff) begin
                  new_rec.rank = cur_rec.rank + IB'(1);
               end
               ram_wr_en   = 1'b1;
               ram_wr_data = new_rec;
               written_in[dat_idx_ff] = 1'b1;
            end
            if (last_dat) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = lbc_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dat_live_ff   <= 1'b0;
         written_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dat_live_ff   <= dat_live_in;
         written_ff    <= written_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff        <= idx_in;
      dat_idx_ff    <= dat_idx_in;
      dev_ff        <= dev_in;
      blk_ff        <= blk_in;
      slot_ff       <= slot_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_rec_ff    <= hit_rec_in;
      vic_ff        <= vic_in;
      vic_idx_ff    <= vic_idx_in;
      vic_rank_ff   <= vic_rank_in;
      rank_ff       <= rank_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_needs_fill  = rsp_fill_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

/* hdl/lbc_ram.sv */
// generic simple dual-port ram with registered read
module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [WIDTH-1:0]               wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
